// ----- hdl/svm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the sample voice mixer.
package svm_pkg;

    // Operation codes of an input item
    localparam logic [2:0] OP_PULL     = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_REGISTER = 3'd2;
    localparam logic [2:0] OP_UNLOAD   = 3'd3;
    localparam logic [2:0] OP_PLAY     = 3'd4;

    // Status codes of a result item
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // Channel setting that selects stereo
    localparam logic [1:0] CHAN_STEREO = 2'd2;
    localparam logic [1:0] CHAN_RESET  = 2'd2;

    // Fixed-point unity values
    localparam logic [16:0] ENV_UNITY = 17'd65536;
    localparam logic [14:0] PAN_UNITY = 15'd16384;

    // Bits retired by the restoring divider, one per cycle
    localparam int DIV_STEPS = 32;

    // Quarter-sine table, Q1.14, 16 segments plus the end point
    localparam logic [14:0] QUARTER_SINE [17] = '{
        15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
        15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
        15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
    };

    typedef struct packed {
        logic [2:0]         operation;
        logic [4:0]         sound_id;
        logic [15:0]        address;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [16:0]        length;
        logic               loop;
        logic signed [15:0] gain;
        logic [15:0]        fade_in;
        logic [15:0]        fade_out;
        logic signed [15:0] pan;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [4:0]         assigned_id;
        logic               status;
        logic [5:0]         active_voices;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quotient;
    } div_rsp_t;

    // Equal-power gain: interpolate the quarter-sine table, round down
    function automatic logic [14:0] pan_curve(input logic [15:0] p);
        logic [4:0]  seg;
        logic [10:0] frac;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [21:0] prod;
        logic [14:0] result;
        seg  = p[15:11];
        frac = p[10:0];
        if (seg[4]) begin
            result = QUARTER_SINE[16];
        end
        else begin
            lo     = QUARTER_SINE[seg];
            hi     = QUARTER_SINE[seg + 5'd1];
            prod   = 22'(hi - lo) * 22'(frac);
            result = lo + 15'(prod >> 11);
        end
        return result;
    endfunction

    // Divide by 2^42 toward zero and clamp to s16
    function automatic logic signed [15:0] scale_clamp(input logic signed [63:0] t);
        logic signed [63:0] adj;
        logic signed [21:0] q;
        logic signed [15:0] result;
        adj = t + (t[63] ? 64'sh3FF_FFFF_FFFF : 64'sh0);
        q   = adj[63:42];
        if (q > 22'sd32767) begin
            result = 16'sh7FFF;
        end
        else if (q < -22'sd32768) begin
            result = 16'sh8000;
        end
        else begin
            result = q[15:0];
        end
        return result;
    endfunction

    // Saturating s16 add
    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        logic signed [15:0] result;
        s = 17'(a) + 17'(b);
        if (s > 17'sd32767) begin
            result = 16'sh7FFF;
        end
        else if (s < -17'sd32768) begin
            result = 16'sh8000;
        end
        else begin
            result = s[15:0];
        end
        return result;
    endfunction

endpackage

// ----- hdl/sample_voice_mixer_top.sv -----
// Top level of the sample voice mixer: sequencer, sound and voice tables, frame memory.
//
// Usage: drive cmd and raise start; the item is taken at a rising edge where start
// is high and busy is low. busy stays high while the item is worked on. Exactly one
// result item follows each input item: done is high for one cycle with result valid,
// and the receiver must take it then, as it cannot hold results off.
// cfg_we/cfg_wdata write the channel count (2 stereo, other values mono) while idle.
// Write, register, unload, play and refused items pass through the execute and done
// states before done. A pull walks every voice in turn through one shared divider and
// one shared multiplier; a playing voice uses the divider once for each fade ramp it
// is on (fade-in, fade-out). busy is already low while done is high, so the next item
// can be taken at the edge that ends done.
// Reset clears the sound table, the voice flags and the channel count (to stereo);
// frame memory and voice records hold garbage until written.
module sample_voice_mixer_top
    import svm_pkg::*;
#(
    parameter int VOICES       = 32,
    parameter int SOUNDS       = 32,
    parameter int SAMPLE_DEPTH = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  cmd,
    output logic      done,
    output out_item_t result,
    input  logic      cfg_we,
    input  logic [1:0] cfg_wdata
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
    localparam int CW = $clog2(SOUNDS + 1);
    localparam int AW = $clog2(SAMPLE_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EXEC = 9'b000000010,
        S_VSEL = 9'b000000100,
        S_PREP = 9'b000001000,
        S_FIN  = 9'b000010000,
        S_FOUT = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_ACC  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg;

    // Control state
    in_item_t    in_reg;
    logic [1:0]  chan_reg;
    logic [CW-1:0] count_reg;
    logic [VOICES-1:0] active_reg;
    logic [16:0] snd_len_reg [SOUNDS];
    logic [VW-1:0] vidx_reg;
    logic [2:0]  mstep_reg;
    logic        done_reg;

    // Payload state
    logic [15:0] snd_base_reg [SOUNDS];
    logic [SW-1:0] v_sound_reg [VOICES];
    logic        v_loop_reg [VOICES];
    logic signed [15:0] v_gain_reg [VOICES];
    logic [15:0] v_fin_reg [VOICES];
    logic [15:0] v_fout_reg [VOICES];
    logic [16:0] v_cursor_reg [VOICES];
    logic [14:0] v_pgl_reg [VOICES];
    logic [14:0] v_pgr_reg [VOICES];

    logic [16:0] cur_reg;
    logic [16:0] len_reg;
    logic [15:0] base_reg;
    logic        loop_reg;
    logic signed [15:0] gain_reg;
    logic [15:0] fin_reg;
    logic [15:0] fout_reg;
    logic [14:0] pgl_reg;
    logic [14:0] pgr_reg;
    logic [16:0] env_reg;
    logic signed [31:0] al_reg;
    logic signed [31:0] ar_reg;
    logic signed [31:0] bl_reg;
    logic signed [31:0] br_reg;
    logic signed [63:0] tl_reg;
    logic signed [15:0] accl_reg;
    logic signed [15:0] accr_reg;
    logic        status_reg;
    logic [4:0]  asg_reg;
    logic [31:0] word_reg;
    out_item_t   result_reg;

    logic [31:0] smem [SAMPLE_DEPTH];

    // Shared units
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;

    svm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    svm_multiplier u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // Item decode
    logic          stereo;
    logic [SW+4:0] sid_w;
    logic [SW-1:0] sid_idx;
    logic          sid_ok;
    logic [SW-1:0] snd_idx;
    logic [16:0]   snd_len_rd;
    logic [15:0]   snd_base_rd;
    logic [CW+4:0] count_w;
    logic [SW-1:0] new_idx;
    logic          table_full;
    logic [AW+15:0] waddr_w;
    logic [AW+17:0] raddr_w;
    logic          free_found;
    logic [VW-1:0] free_idx;
    logic signed [15:0] pan_c;
    logic [15:0]   pan_p;
    logic [VOICES-1:0] unload_hit;
    logic [6:0]    active_cnt;

    assign stereo  = chan_reg == CHAN_STEREO;
    assign sid_w   = (SW + 5)'(in_reg.sound_id);
    assign sid_idx = sid_w[SW-1:0];
    assign sid_ok  = (32'(in_reg.sound_id) < 32'(SOUNDS))
                  && (32'(in_reg.sound_id) < 32'(count_reg))
                  && (snd_len_rd != 17'd0);
    assign count_w = (CW + 5)'(count_reg);
    assign new_idx = count_w[SW-1:0];
    assign table_full = 32'(count_reg) >= 32'(SOUNDS);
    assign waddr_w = (AW + 16)'(in_reg.address);
    assign raddr_w = (AW + 18)'(base_reg) + (AW + 18)'(cur_reg);

    // Sound table read: slot of the item while executing, voice's slot while mixing
    assign snd_idx     = (state_reg == S_EXEC) ? sid_idx : v_sound_reg[vidx_reg];
    assign snd_len_rd  = snd_len_reg[snd_idx];
    assign snd_base_rd = snd_base_reg[snd_idx];

    // Find the lowest free voice
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!active_reg[v]) begin
                free_found = 1'b1;
                free_idx   = VW'(v);
            end
        end
    end

    // Voices that play the slot being unloaded
    always_comb begin
        for (int v = 0; v < VOICES; v++) begin
            unload_hit[v] = active_reg[v] && (v_sound_reg[v] == sid_idx);
        end
    end

    // Clamp pan and shift to 0..32768
    always_comb begin
        if (in_reg.pan < -16'sd16384) begin
            pan_c = -16'sd16384;
        end
        else if (in_reg.pan > 16'sd16384) begin
            pan_c = 16'sd16384;
        end
        else begin
            pan_c = in_reg.pan;
        end
        pan_p = 16'(pan_c + 16'sd16384);
    end

    assign active_cnt = 7'($countones(active_reg));

    // Voice fetch in the select state
    logic        v_act;
    logic [16:0] v_cur;
    logic        v_at_end;
    logic        last_voice;

    assign v_act      = active_reg[vidx_reg];
    assign v_cur      = v_cursor_reg[vidx_reg];
    assign v_at_end   = v_cur >= snd_len_rd;
    assign last_voice = vidx_reg == VW'(VOICES - 1);

    // Envelope ramp conditions for the voice in hand
    logic fin_c;
    logic fout_c;

    assign fin_c  = (fin_reg != 16'd0) && (cur_reg < 17'(fin_reg));
    assign fout_c = !loop_reg && (fout_reg != 16'd0)
                 && ((18'(cur_reg) + 18'(fout_reg)) >= 18'(len_reg));

    // Divider requests
    logic [16:0] rem_len;
    assign rem_len = len_reg - cur_reg;

    always_comb begin
        div_req.start    = ((state_reg == S_PREP) && (fin_c || fout_c))
                        || ((state_reg == S_FIN) && div_rsp.done && fout_c);
        if ((state_reg == S_PREP) && fin_c) begin
            div_req.dividend = {cur_reg[15:0], 16'd0};
            div_req.divisor  = fin_reg;
        end
        else begin
            div_req.dividend = {rem_len[15:0], 16'd0};
            div_req.divisor  = fout_reg;
        end
    end

    // Multiplier operand schedule
    logic [14:0] pgl_eff;
    assign pgl_eff = stereo ? pgl_reg : PAN_UNITY;

    always_comb begin
        unique case (mstep_reg)
            3'd0: begin
                mul_a = 32'(env_reg);
                mul_b = 32'(pgl_eff);
            end
            3'd1: begin
                mul_a = 32'(env_reg);
                mul_b = 32'(pgr_reg);
            end
            3'd2: begin
                mul_a = 32'(signed'(word_reg[15:0]));
                mul_b = 32'(gain_reg);
            end
            3'd3: begin
                mul_a = 32'(signed'(word_reg[31:16]));
                mul_b = 32'(gain_reg);
            end
            3'd4: begin
                mul_a = bl_reg;
                mul_b = al_reg;
            end
            3'd5: begin
                mul_a = br_reg;
                mul_b = ar_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next cursor and retire check after mixing
    logic [16:0] cur_inc;
    assign cur_inc = cur_reg + 17'd1;

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            chan_reg   <= CHAN_RESET;
            count_reg  <= '0;
            active_reg <= '0;
            vidx_reg   <= '0;
            mstep_reg  <= '0;
            done_reg   <= 1'b0;
            for (int s = 0; s < SOUNDS; s++) begin
                snd_len_reg[s] <= '0;
            end
        end
        else begin
            done_reg <= 1'b0;
            if (cfg_we) begin
                chan_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_DONE;
                    vidx_reg  <= '0;
                    unique case (in_reg.operation)
                        OP_PULL: begin
                            state_reg <= S_VSEL;
                        end
                        OP_REGISTER: begin
                            if (!table_full && (in_reg.length != 17'd0)) begin
                                snd_len_reg[new_idx] <= in_reg.length;
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                        OP_UNLOAD: begin
                            if (sid_ok) begin
                                active_reg <= active_reg & ~unload_hit;
                                snd_len_reg[sid_idx] <= '0;
                            end
                        end
                        OP_PLAY: begin
                            if (sid_ok && free_found) begin
                                active_reg[free_idx] <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_VSEL: begin
                    if (v_act && (snd_len_rd != 17'd0)
                        && (!v_at_end || v_loop_reg[vidx_reg])) begin
                        state_reg <= S_PREP;
                    end
                    else begin
                        if (v_act) begin
                            active_reg[vidx_reg] <= 1'b0;
                        end
                        if (last_voice) begin
                            state_reg <= S_DONE;
                        end
                        else begin
                            vidx_reg <= vidx_reg + VW'(1);
                        end
                    end
                end
                S_PREP: begin
                    mstep_reg <= '0;
                    if (fin_c) begin
                        state_reg <= S_FIN;
                    end
                    else if (fout_c) begin
                        state_reg <= S_FOUT;
                    end
                    else begin
                        state_reg <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (div_rsp.done) begin
                        state_reg <= fout_c ? S_FOUT : S_MUL;
                    end
                end
                S_FOUT: begin
                    if (div_rsp.done) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd5) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!loop_reg && (cur_inc >= len_reg)) begin
                        active_reg[vidx_reg] <= 1'b0;
                    end
                    if (last_voice) begin
                        state_reg <= S_DONE;
                    end
                    else begin
                        vidx_reg  <= vidx_reg + VW'(1);
                        state_reg <= S_VSEL;
                    end
                end
                S_DONE: begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        if ((state_reg == S_IDLE) && start) begin
            in_reg <= cmd;
        end
        unique case (state_reg)
            S_EXEC: begin
                accl_reg   <= '0;
                accr_reg   <= '0;
                asg_reg    <= '0;
                status_reg <= STATUS_DONE;
                unique case (in_reg.operation)
                    OP_PULL, OP_WRITE: begin
                    end
                    OP_REGISTER: begin
                        if (table_full || (in_reg.length == 17'd0)) begin
                            status_reg <= STATUS_REFUSED;
                        end
                        else begin
                            snd_base_reg[new_idx] <= in_reg.address;
                            asg_reg <= count_w[4:0];
                        end
                    end
                    OP_UNLOAD: begin
                        if (!sid_ok) begin
                            status_reg <= STATUS_REFUSED;
                        end
                    end
                    OP_PLAY: begin
                        if (!sid_ok || !free_found) begin
                            status_reg <= STATUS_REFUSED;
                        end
                        else begin
                            v_sound_reg[free_idx]  <= sid_idx;
                            v_loop_reg[free_idx]   <= in_reg.loop;
                            v_gain_reg[free_idx]   <= in_reg.gain;
                            v_fin_reg[free_idx]    <= in_reg.fade_in;
                            v_fout_reg[free_idx]   <= in_reg.fade_out;
                            v_cursor_reg[free_idx] <= '0;
                            v_pgr_reg[free_idx]    <= pan_curve(pan_p);
                            v_pgl_reg[free_idx]    <= pan_curve(16'd32768 - pan_p);
                        end
                    end
                    default: begin
                        status_reg <= STATUS_REFUSED;
                    end
                endcase
            end
            S_VSEL: begin
                // Wrap a looping voice before it plays
                cur_reg  <= v_at_end ? 17'd0 : v_cur;
                len_reg  <= snd_len_rd;
                base_reg <= snd_base_rd;
                loop_reg <= v_loop_reg[vidx_reg];
                gain_reg <= v_gain_reg[vidx_reg];
                fin_reg  <= v_fin_reg[vidx_reg];
                fout_reg <= v_fout_reg[vidx_reg];
                pgl_reg  <= v_pgl_reg[vidx_reg];
                pgr_reg  <= v_pgr_reg[vidx_reg];
            end
            S_PREP: begin
                env_reg <= ENV_UNITY;
            end
            S_FIN: begin
                if (div_rsp.done) begin
                    env_reg <= div_rsp.quotient;
                end
            end
            S_FOUT: begin
                if (div_rsp.done && (div_rsp.quotient < env_reg)) begin
                    env_reg <= div_rsp.quotient;
                end
            end
            S_MUL: begin
                unique case (mstep_reg)
                    3'd1: al_reg <= mul_p[31:0];
                    3'd2: ar_reg <= mul_p[31:0];
                    3'd3: bl_reg <= mul_p[31:0];
                    3'd4: br_reg <= mul_p[31:0];
                    3'd5: tl_reg <= mul_p;
                    default: begin
                    end
                endcase
            end
            S_ACC: begin
                accl_reg <= sat_add(accl_reg, scale_clamp(tl_reg));
                accr_reg <= sat_add(accr_reg, scale_clamp(mul_p));
                v_cursor_reg[vidx_reg] <= cur_inc;
            end
            S_DONE: begin
                result_reg.left_out      <= accl_reg;
                result_reg.right_out     <= stereo ? accr_reg : 16'sd0;
                result_reg.assigned_id   <= asg_reg;
                result_reg.status        <= status_reg;
                result_reg.active_voices <= active_cnt[5:0];
            end
            default: begin
            end
        endcase
    end

    // Frame memory: write on a write item, registered read when a voice is prepared
    always_ff @(posedge clk) begin
        if ((state_reg == S_EXEC) && (in_reg.operation == OP_WRITE)) begin
            smem[waddr_w[AW-1:0]] <= {in_reg.right_sample, in_reg.left_sample};
        end
        if (state_reg == S_PREP) begin
            word_reg <= smem[raddr_w[AW-1:0]];
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hdl/svm_divider.sv -----
// Restoring divider for the fade envelopes, one quotient bit per cycle.
module svm_divider
    import svm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  count_reg;
    logic [16:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] dsr_reg;
    logic [16:0] shifted;
    logic        fits;

    // Trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg[15:0], quo_reg[31]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    // Control: step count and done pulse
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= 6'(DIV_STEPS);
            end
            else if (busy_reg) begin
                count_reg <= count_reg - 6'd1;
                if (count_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend in, the quotient bits out
    always_ff @(posedge clk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg) begin
            rem_reg <= fits ? (shifted - {1'b0, dsr_reg}) : shifted;
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[16:0];

endmodule

// ----- hdl/svm_multiplier.sv -----
// Shared signed 32x32 multiplier with a registered product.
module svm_multiplier
    import svm_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;

    // Register the product each cycle
    always_ff @(posedge clk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ----- tb/sv/sample_voice_mixer_top_tb.sv -----
// Testbench for the sample voice mixer: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module sample_voice_mixer_top_tb;
    import svm_pkg::*;

    localparam int N_VOICES       = 32;
    localparam int N_SOUNDS       = 32;
    localparam int DEPTH          = 65536;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 120;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  cmd;
    logic      done;
    out_item_t result;
    logic      cfg_we;
    logic [1:0] cfg_wdata;

    // Mirror of the mixer state
    bit [31:0]   frame_mem [bit [15:0]];
    bit [15:0]   sound_base [N_SOUNDS];
    int unsigned sound_len [N_SOUNDS];
    int unsigned sounds_claimed;
    bit          voice_on [N_VOICES];
    int unsigned voice_sound [N_VOICES];
    bit          voice_loop [N_VOICES];
    int          voice_gain [N_VOICES];
    int unsigned voice_fade_in [N_VOICES];
    int unsigned voice_fade_out [N_VOICES];
    int unsigned voice_cursor [N_VOICES];
    int unsigned voice_gain_l [N_VOICES];
    int unsigned voice_gain_r [N_VOICES];
    bit [1:0]    chan_mode;

    out_item_t expected_q [$];
    int        errors;
    int        items_sent;
    int        frames_checked;
    int        refusals;
    int        quiet_cycles;
    int        burst_left;

    sample_voice_mixer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Equal-power gain from the quarter-sine table, rounded down
    function automatic int unsigned sine_gain(input int unsigned p);
        int unsigned seg;
        int unsigned frac;
        seg  = p >> 11;
        frac = p & 2047;
        if (seg >= 16)
        begin
            return QUARTER_SINE[16];
        end
        return QUARTER_SINE[seg] + (((QUARTER_SINE[seg + 1] - QUARTER_SINE[seg]) * frac) >> 11);
    endfunction

    function automatic int sat16(input longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return int'(v);
    endfunction

    // One voice's contribution: sample x gain x envelope x pan over 2^42, toward zero
    function automatic int voice_part(input int s, input int g, input longint env,
                                      input longint pg);
        longint prod;
        prod = longint'(s) * longint'(g);
        prod = prod * env;
        prod = prod * pg;
        return sat16(prod / (longint'(1) << 42));
    endfunction

    // Mix one output frame and advance every active voice
    function automatic void mix_frame(output int lo, output int ro);
        int          acc_l;
        int          acc_r;
        int unsigned s;
        int unsigned len;
        int unsigned cur;
        longint      env;
        bit [31:0]   word;
        bit [15:0]   addr;
        acc_l = 0;
        acc_r = 0;
        for (int v = 0; v < N_VOICES; v++)
        begin
            if (!voice_on[v])
            begin
                continue;
            end
            s   = voice_sound[v];
            len = sound_len[s];
            if (len == 0)
            begin
                voice_on[v] = 1'b0;
                continue;
            end
            if (voice_cursor[v] >= len)
            begin
                if (voice_loop[v])
                begin
                    voice_cursor[v] = 0;
                end
                else
                begin
                    voice_on[v] = 1'b0;
                    continue;
                end
            end
            cur = voice_cursor[v];
            env = 65536;
            if (voice_fade_in[v] > 0 && cur < voice_fade_in[v])
            begin
                env = (longint'(cur) << 16) / voice_fade_in[v];
            end
            if (!voice_loop[v] && voice_fade_out[v] > 0
                && longint'(cur) + voice_fade_out[v] >= len)
            begin
                if ((longint'(len - cur) << 16) / voice_fade_out[v] < env)
                begin
                    env = (longint'(len - cur) << 16) / voice_fade_out[v];
                end
            end
            addr = 16'(sound_base[s] + cur);
            word = frame_mem.exists(addr) ? frame_mem[addr] : 32'd0;
            if (chan_mode == CHAN_STEREO)
            begin
                acc_l = sat16(longint'(acc_l) + voice_part($signed(word[15:0]), voice_gain[v],
                                                            env, voice_gain_l[v]));
                acc_r = sat16(longint'(acc_r) + voice_part($signed(word[31:16]), voice_gain[v],
                                                            env, voice_gain_r[v]));
            end
            else
            begin
                acc_l = sat16(longint'(acc_l) + voice_part($signed(word[15:0]), voice_gain[v],
                                                            env, 16384));
            end
            voice_cursor[v] = cur + 1;
            if (!voice_loop[v] && voice_cursor[v] >= len)
            begin
                voice_on[v] = 1'b0;
            end
        end
        lo = acc_l;
        ro = (chan_mode == CHAN_STEREO) ? acc_r : 0;
    endfunction

    // Apply one item to the mirror state and return the result it must give
    function automatic out_item_t mixer_predict(input in_item_t it);
        out_item_t   r;
        int          lo;
        int          ro;
        int          pan_q;
        int unsigned p;
        int          v;
        int          n;
        r = '0;
        case (it.operation)
            OP_PULL:
            begin
                mix_frame(lo, ro);
                r.left_out  = 16'(lo);
                r.right_out = 16'(ro);
            end
            OP_WRITE:
            begin
                frame_mem[it.address] = {it.right_sample, it.left_sample};
            end
            OP_REGISTER:
            begin
                if (sounds_claimed >= N_SOUNDS || it.length == 0)
                begin
                    r.status = STATUS_REFUSED;
                end
                else
                begin
                    sound_base[sounds_claimed] = it.address;
                    sound_len[sounds_claimed]  = it.length;
                    r.assigned_id = 5'(sounds_claimed);
                    sounds_claimed++;
                end
            end
            OP_UNLOAD, OP_PLAY:
            begin
                if (it.sound_id >= sounds_claimed || sound_len[it.sound_id] == 0)
                begin
                    r.status = STATUS_REFUSED;
                end
                else if (it.operation == OP_UNLOAD)
                begin
                    for (int k = 0; k < N_VOICES; k++)
                    begin
                        if (voice_on[k] && voice_sound[k] == it.sound_id)
                        begin
                            voice_on[k] = 1'b0;
                        end
                    end
                    sound_len[it.sound_id] = 0;
                end
                else
                begin
                    pan_q = it.pan;
                    if (pan_q < -16384)
                    begin
                        pan_q = -16384;
                    end
                    if (pan_q > 16384)
                    begin
                        pan_q = 16384;
                    end
                    p = pan_q + 16384;
                    for (v = 0; v < N_VOICES; v++)
                    begin
                        if (!voice_on[v])
                        begin
                            break;
                        end
                    end
                    if (v >= N_VOICES)
                    begin
                        r.status = STATUS_REFUSED;
                    end
                    else
                    begin
                        voice_sound[v]    = it.sound_id;
                        voice_loop[v]     = it.loop;
                        voice_gain[v]     = it.gain;
                        voice_fade_in[v]  = it.fade_in;
                        voice_fade_out[v] = it.fade_out;
                        voice_cursor[v]   = 0;
                        voice_gain_l[v]   = sine_gain(32768 - p);
                        voice_gain_r[v]   = sine_gain(p);
                        voice_on[v]       = 1'b1;
                    end
                end
            end
            default:
            begin
                r.status = STATUS_REFUSED;
            end
        endcase
        n = 0;
        for (int k = 0; k < N_VOICES; k++)
        begin
            n += voice_on[k];
        end
        r.active_voices = 6'(n);
        return r;
    endfunction

    // Send one item and hold start until the mixer takes it
    task automatic send_item(input in_item_t it);
        out_item_t e;
        cmd   <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        e = mixer_predict(it);
        if (e.status == STATUS_REFUSED)
        begin
            refusals++;
        end
        expected_q.push_back(e);
        items_sent++;
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Drop start and wait until every expected result is in
    task automatic drain();
        stop_sending();
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Bursts of random length separated by random gaps
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(10, 40);
        if ($urandom_range(0, 3) != 0)
        begin
            stop_sending();
            repeat ($urandom_range(0, 11)) @(posedge clk);
        end
    endtask

    task automatic write_channels(input bit [1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        chan_mode = value;
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t noise_item(input logic [2:0] op);
        in_item_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it.operation = op;
        return it;
    endfunction

    // Fill any frame an active voice is about to read that was never written
    task automatic fill_next_frames();
        in_item_t    it;
        int unsigned s;
        int unsigned cur;
        bit [15:0]   addr;
        for (int v = 0; v < N_VOICES; v++)
        begin
            if (!voice_on[v] || sound_len[voice_sound[v]] == 0)
            begin
                continue;
            end
            s   = voice_sound[v];
            cur = voice_cursor[v];
            if (cur >= sound_len[s])
            begin
                if (!voice_loop[v])
                begin
                    continue;
                end
                cur = 0;
            end
            addr = 16'(sound_base[s] + cur);
            if (!frame_mem.exists(addr))
            begin
                it = noise_item(OP_WRITE);
                it.address = addr;
                send_item(it);
            end
        end
    endtask

    task automatic pull_frame();
        fill_next_frames();
        send_item(noise_item(OP_PULL));
        frames_checked++;
    endtask

    task automatic register_sound(input bit [15:0] base, input bit [16:0] len);
        in_item_t it;
        it = noise_item(OP_REGISTER);
        it.address = base;
        it.length  = len;
        send_item(it);
    endtask

    task automatic play_sound(input bit [4:0] sid, input bit lp, input bit [15:0] g,
                              input bit [15:0] fi, input bit [15:0] fo, input bit [15:0] pn);
        in_item_t it;
        it = noise_item(OP_PLAY);
        it.sound_id = sid;
        it.loop     = lp;
        it.gain     = g;
        it.fade_in  = fi;
        it.fade_out = fo;
        it.pan      = pn;
        send_item(it);
    endtask

    task automatic slot_item(input logic [2:0] op, input bit [4:0] sid);
        in_item_t it;
        it = noise_item(op);
        it.sound_id = sid;
        send_item(it);
    endtask

    // Refusals, wrapped addresses, clamped pan, fades, one-shot end and unload
    task automatic test_directed();
        register_sound(16'd5, 17'd0);
        slot_item(OP_UNLOAD, 5'd3);
        play_sound(5'd3, 1'b1, 16'h1000, 16'd0, 16'd0, 16'd0);
        register_sound(16'hFFFE, 17'd4);
        register_sound(16'd100, 17'h1FFFF);
        play_sound(5'd0, 1'b0, 16'h7FFF, 16'd2, 16'd3, 16'h8000);
        play_sound(5'd1, 1'b1, 16'h8000, 16'd0, 16'd0, 16'h7FFF);
        play_sound(5'd0, 1'b1, 16'h1000, 16'hFFFF, 16'hFFFF, 16'd0);
        repeat (6) pull_frame();
        slot_item(OP_UNLOAD, 5'd1);
        pull_frame();
        play_sound(5'd1, 1'b1, 16'h1000, 16'd0, 16'd0, 16'd0);
        slot_item(OP_UNLOAD, 5'd31);
        send_item(noise_item(3'd5));
        send_item(noise_item(3'd7));
        pull_frame();
    endtask

    // Register a sound, then ask one more time than there are voices to play slot 3, which is not registered
    task automatic test_voice_exhaustion();
        register_sound($urandom, 17'd1);
        for (int k = 0; k <= N_VOICES; k++)
        begin
            play_sound(5'd3, 1'b1, $urandom, 16'd0, 16'd0, $urandom_range(0, 32768) - 16384);
        end
        pull_frame();
        slot_item(OP_UNLOAD, 5'd3);
        pull_frame();
    endtask

    // Mostly well-formed traffic with random content, some noise
    task automatic test_random_phase(input int count);
        int          pick;
        bit [4:0]    sid;
        bit [16:0]   len;
        bit [15:0]   fi;
        bit [15:0]   fo;
        bit [15:0]   pn;
        for (int k = 0; k < count; k++)
        begin
            if (k == count / 2)
            begin
                drain();
            end
            pick = $urandom_range(0, 99);
            sid  = (sounds_claimed > 0 && $urandom_range(0, 4) != 0)
                   ? 5'($urandom_range(0, sounds_claimed - 1)) : 5'($urandom);
            if (pick < 35)
            begin
                pull_frame();
            end
            else if (pick < 48)
            begin
                send_item(noise_item(OP_WRITE));
            end
            else if (pick < 57)
            begin
                case ($urandom_range(0, 9))
                    0: len = 17'($urandom_range(65530, 131071));
                    1: len = 17'd0;
                    2, 3: len = 17'($urandom_range(49, 300));
                    default: len = 17'($urandom_range(1, 48));
                endcase
                register_sound($urandom, len);
            end
            else if (pick < 64)
            begin
                slot_item(OP_UNLOAD, sid);
            end
            else if (pick < 95)
            begin
                fi = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 20));
                fo = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 20));
                if ($urandom_range(0, 9) == 0)
                begin
                    fi = $urandom;
                    fo = $urandom;
                end
                pn = $urandom_range(0, 7) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(0, 32768) - 16384);
                play_sound(sid, $urandom_range(0, 1), $urandom, fi, fo, pn);
            end
            else
            begin
                send_item(noise_item(3'($urandom_range(5, 7))));
            end
            pace();
        end
    endtask

    // Compare each result with the oldest expectation
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                check_field("left_out", e.left_out, result.left_out);
                check_field("right_out", e.right_out, result.right_out);
                check_field("assigned_id", e.assigned_id, result.assigned_id);
                check_field("status", e.status, result.status);
                check_field("active_voices", e.active_voices, result.active_voices);
            end
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = 2'd0;
        chan_mode      = CHAN_RESET;
        sounds_claimed = 0;
        errors         = 0;
        items_sent     = 0;
        frames_checked = 0;
        refusals       = 0;
        burst_left     = 0;
        foreach (sound_len[k])
        begin
            sound_len[k]  = 0;
            sound_base[k] = '0;
        end
        foreach (voice_on[k])
        begin
            voice_on[k] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_voice_exhaustion();
        test_random_phase(PHASE_ITEMS);
        write_channels(2'd1);
        test_random_phase(PHASE_ITEMS);
        write_channels(2'd0);
        test_random_phase(PHASE_ITEMS / 2);
        write_channels(2'd3);
        test_random_phase(PHASE_ITEMS / 2);
        write_channels(2'd2);
        test_random_phase(PHASE_ITEMS);

        drain();
        repeat (40) @(posedge clk);
        $display("covered %0d items, %0d mixed frames, %0d refusals, %0d sound slots claimed",
                 items_sent, frames_checked, refusals, sounds_claimed);
        $display("channel settings stereo, mono and the odd codes 0 and 3; %0d errors", errors);
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
